// File: sv/cpk_pkg.sv
// cpk_pkg: shared constants, register codes and the control struct that
// travels from the front end through the queue to the byte packer.
// no dependencies.
`default_nettype none

package cpk_pkg;

    // default generator width and register reset values
    localparam int GEN_BITS_DEF = 17;
    localparam int GEN_RESET    = 11;
    localparam logic MODE_RESET = 1'b0;
    localparam logic [2:0] PAD_RESET = 3'd0;

    localparam int BYTE_BITS = 8;
    localparam int NIB_BITS  = 4;
    localparam int CFG_IDX_W = 2;

    // word mode codes
    localparam logic MODE_NIBBLE = 1'b0;
    localparam logic MODE_BYTE   = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GEN_POLY  = 2'd0,
        REG_WORD_MODE = 2'd1,
        REG_PAD_BITS  = 2'd2
    } cfg_reg_t;

    // per-item control captured by the front end
    typedef struct packed {
        logic       hdr;      // header byte goes out before this item's bytes
        logic [2:0] hdr_val;  // padding count carried in the header
        logic [2:0] pad;      // zero bits ahead of the first codeword
        logic       mode;     // word mode at accept time
    } cpk_ctl_t;

endpackage

`default_nettype wire

// File: sv/cpk_front.sv
// cpk_front: accepts input beats, marks the first item for the header and
// computes the crc remainders of the datawords. depends on cpk_pkg.
`default_nettype none

module cpk_front #(
    parameter int GEN_BITS = cpk_pkg::GEN_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         data_valid,
    output logic                         data_stall,
    input  logic [7:0]                   data_byte,
    input  logic [GEN_BITS-2:0]          poly_low,
    input  logic [$clog2(GEN_BITS)-1:0]  gen_r,
    input  logic                         word_mode,
    input  logic [2:0]                   pad_bits,
    input  logic                         q_full,
    output logic                         q_push,
    output cpk_pkg::cpk_ctl_t            q_ctl,
    output logic [$clog2(GEN_BITS)-1:0]  q_r,
    output logic [7:0]                   q_data,
    output logic [GEN_BITS-2:0]          rem_a,
    output logic [GEN_BITS-2:0]          rem_b
);

    logic header_done_reg;
    logic header_done_next;
    logic accept;

    // four msb-first steps of the crc shift register, generator aligned to the top
    function automatic logic [GEN_BITS-2:0] crc_nib(
        input logic [GEN_BITS-2:0] seed,
        input logic [3:0]          nib,
        input logic [GEN_BITS-2:0] poly
    );
        logic [GEN_BITS-2:0] c;
        logic                fb;
        c = seed;
        for (int i = cpk_pkg::NIB_BITS - 1; i >= 0; i--)
        begin
            fb = nib[i] ^ c[GEN_BITS-2];
            c  = c << 1;
            if (fb)
            begin
                c = c ^ poly;
            end
        end
        return c;
    endfunction

    // input handshake
    assign accept     = data_valid && !q_full;
    assign data_stall = q_full;
    assign q_push     = accept;

    // classify: header and padding only on the first item after reset
    always_comb
    begin
        q_ctl.hdr     = !header_done_reg;
        q_ctl.hdr_val = pad_bits;
        q_ctl.pad     = header_done_reg ? 3'd0 : pad_bits;
        q_ctl.mode    = word_mode;
    end

    assign q_r    = gen_r;
    assign q_data = data_byte;

    // high nibble from zero; low nibble continues it in byte mode
    assign rem_a = crc_nib('0, data_byte[7:4], poly_low);
    assign rem_b = crc_nib((word_mode == cpk_pkg::MODE_BYTE) ? rem_a : '0,
                           data_byte[3:0], poly_low);

    assign header_done_next = header_done_reg || accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_done_reg <= 1'b0;
        end
        else
        begin
            header_done_reg <= header_done_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/cpk_queue.sv
// cpk_queue: two-entry queue that decouples the crc front end from the
// byte packer. no dependencies.
`default_nettype none

module cpk_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    // pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: sv/cpk_back.sv
// cpk_back: places codeword bits into a left-aligned bit accumulator and sends
// one byte beat per unstalled cycle via the output register. depends on cpk_pkg.
`default_nettype none

module cpk_back #(
    parameter int GEN_BITS = cpk_pkg::GEN_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    output logic                         q_pop,
    input  cpk_pkg::cpk_ctl_t            q_ctl,
    input  logic [$clog2(GEN_BITS)-1:0]  q_r,
    input  logic [7:0]                   q_data,
    input  logic [GEN_BITS-2:0]          rem_a,
    input  logic [GEN_BITS-2:0]          rem_b,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [7:0]                   out_byte,
    output logic                         is_header,
    output logic                         last_of_run
);

    // accumulator holds up to 7 pending bits plus the longest item
    localparam int AW   = 2 * GEN_BITS + 21;
    localparam int CW   = $clog2(AW);
    localparam int C1W  = GEN_BITS + 7;
    localparam int C2W  = GEN_BITS + 3;
    localparam int BB   = cpk_pkg::BYTE_BITS;

    logic [AW-1:0]  acc_reg;
    logic [AW-1:0]  acc_next;
    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  cnt_next;
    logic           hdr_pend_reg;
    logic           hdr_pend_next;
    logic [2:0]     hdr_val_reg;
    logic [2:0]     hdr_val_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic [7:0]     out_byte_reg;
    logic [7:0]     out_byte_next;
    logic           out_hdr_reg;
    logic           out_hdr_next;
    logic           out_last_reg;
    logic           out_last_next;

    logic           out_free;
    logic           emit_hdr;
    logic           emit_data;
    logic           load;
    logic [AW-1:0]  base_acc;
    logic [CW-1:0]  base_cnt;
    logic [CW-1:0]  off1;
    logic [CW-1:0]  off2;
    logic [CW-1:0]  gain;
    logic [C1W-1:0] cw1;
    logic [C2W-1:0] cw2;
    logic [AW-1:0]  ins1;
    logic [AW-1:0]  ins2;

    // what goes out this cycle
    assign out_free  = !out_valid_reg || !result_stall;
    assign emit_hdr  = out_free && hdr_pend_reg;
    assign emit_data = out_free && !hdr_pend_reg && (cnt_reg >= CW'(BB));

    // accumulator after this cycle's byte leaves
    assign base_acc = emit_data ? (acc_reg << BB) : acc_reg;
    assign base_cnt = emit_data ? (cnt_reg - CW'(BB)) : cnt_reg;

    // take the next item once less than a byte remains
    assign load  = q_valid && !hdr_pend_reg && (base_cnt < CW'(BB));
    assign q_pop = load;

    // codewords, left aligned; bits past the remainder length are zero
    always_comb
    begin
        if (q_ctl.mode == cpk_pkg::MODE_BYTE)
        begin
            cw1  = {q_data, rem_b};
            gain = CW'(BB) + CW'(q_r);
        end
        else
        begin
            cw1  = {q_data[7:4], rem_a, 4'b0000};
            gain = CW'(BB) + CW'(q_r) + CW'(q_r);
        end
        cw2  = {q_data[3:0], rem_b};
        off1 = base_cnt + CW'(q_ctl.pad);
        off2 = off1 + CW'(cpk_pkg::NIB_BITS) + CW'(q_r);
        ins1 = {cw1, {(AW - C1W){1'b0}}} >> off1;
        ins2 = (q_ctl.mode == cpk_pkg::MODE_BYTE) ? '0
             : ({cw2, {(AW - C2W){1'b0}}} >> off2);
    end

    // accumulator and header tracking
    always_comb
    begin
        acc_next      = base_acc;
        cnt_next      = base_cnt;
        hdr_pend_next = emit_hdr ? 1'b0 : hdr_pend_reg;
        hdr_val_next  = hdr_val_reg;
        if (load)
        begin
            acc_next      = base_acc | ins1 | ins2;
            cnt_next      = base_cnt + CW'(q_ctl.pad) + gain;
            hdr_pend_next = q_ctl.hdr;
            hdr_val_next  = q_ctl.hdr_val;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_hdr_next   = out_hdr_reg;
        out_last_next  = out_last_reg;
        if (out_free)
        begin
            out_valid_next = emit_hdr || emit_data;
            out_byte_next  = emit_hdr ? {5'b00000, hdr_val_reg} : acc_reg[AW-1 -: BB];
            out_hdr_next   = emit_hdr;
            out_last_next  = emit_data && (cnt_reg < CW'(2 * BB));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            cnt_reg       <= '0;
            hdr_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            hdr_pend_reg  <= hdr_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hdr_val_reg  <= hdr_val_next;
        out_byte_reg <= out_byte_next;
        out_hdr_reg  <= out_hdr_next;
        out_last_reg <= out_last_next;
    end

    assign result_valid = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign is_header    = out_hdr_reg;
    assign last_of_run  = out_last_reg;

    // the header byte is always followed by data bytes of the same item
    a_hdr_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && is_header) |-> !last_of_run)
        else $error("header beat marked as last of run");

    // every item brings at least one full byte
    a_load_gives_byte: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (hdr_pend_reg || (cnt_reg >= CW'(BB))))
        else $error("item loaded without a full byte available");

    // a pending header always has its item's bits behind it
    a_hdr_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_pend_reg |-> (cnt_reg >= CW'(BB)))
        else $error("header pending with no data bits");

endmodule

`default_nettype wire

// File: sv/crc_codeword_packer.sv
// crc_codeword_packer: crc codeword encoder with a configurable generator,
// packed msb first into a byte stream with a leading padding header.
// path: an accepted beat passes the queue, bit accumulator and output register.
// throughput: one result beat per cycle while result_stall is low; an item yields
// 1 to 6 data bytes at the default width, plus the header byte on the first item.
// reset: clears pending bits, the header flag and the queue; registers to defaults.
`default_nettype none

module crc_codeword_packer #(
    parameter int GEN_BITS = cpk_pkg::GEN_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   data_valid,
    output logic                                   data_stall,
    input  logic [7:0]                             data_byte,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output logic [7:0]                             out_byte,
    output logic                                   is_header,
    output logic                                   last_of_run,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [cpk_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [((GEN_BITS > 3) ? GEN_BITS : 3)-1:0] cfg_data
);

    localparam int RW = $clog2(GEN_BITS);
    localparam int QW = $bits(cpk_pkg::cpk_ctl_t) + RW + 8 + 2 * (GEN_BITS - 1);

    // degree of the generator: position of its top set bit, zero for a zero generator
    function automatic logic [RW-1:0] gen_r_of(input logic [GEN_BITS-1:0] g);
        logic [RW-1:0] r;
        r = '0;
        for (int b = 0; b < GEN_BITS; b++)
        begin
            if (g[b])
            begin
                r = RW'(b);
            end
        end
        return r;
    endfunction

    // generator shifted so its top bit sits just above the crc register
    function automatic logic [GEN_BITS-2:0] gen_low_of(
        input logic [GEN_BITS-1:0] g,
        input logic [RW-1:0]       r
    );
        logic [GEN_BITS-1:0] a;
        a = g << (GEN_BITS - 1 - int'(r));
        return a[GEN_BITS-2:0];
    endfunction

    localparam logic [GEN_BITS-1:0] GEN_RST = GEN_BITS'(cpk_pkg::GEN_RESET);
    localparam logic [RW-1:0]       R_RST   = gen_r_of(GEN_RST);
    localparam logic [GEN_BITS-2:0] LOW_RST = gen_low_of(GEN_RST, R_RST);

    logic [RW-1:0]       gen_r_reg;
    logic [RW-1:0]       gen_r_next;
    logic [GEN_BITS-2:0] poly_low_reg;
    logic [GEN_BITS-2:0] poly_low_next;
    logic                mode_reg;
    logic                mode_next;
    logic [2:0]          pad_reg;
    logic [2:0]          pad_next;
    logic [RW-1:0]       cfg_r;
    logic [GEN_BITS-2:0] cfg_low;

    cpk_pkg::cpk_ctl_t   f_ctl;
    logic [RW-1:0]       f_r;
    logic [7:0]          f_data;
    logic [GEN_BITS-2:0] f_rem_a;
    logic [GEN_BITS-2:0] f_rem_b;
    logic                q_push;
    logic                q_full;
    logic                q_pop;
    logic                q_valid;
    logic [QW-1:0]       q_pop_data;
    cpk_pkg::cpk_ctl_t   b_ctl;
    logic [RW-1:0]       b_r;
    logic [7:0]          b_data;
    logic [GEN_BITS-2:0] b_rem_a;
    logic [GEN_BITS-2:0] b_rem_b;

    // configuration writes, generator decoded once at write time
    assign cfg_ready = 1'b1;
    assign cfg_r     = gen_r_of(cfg_data[GEN_BITS-1:0]);
    assign cfg_low   = gen_low_of(cfg_data[GEN_BITS-1:0], cfg_r);

    always_comb
    begin
        gen_r_next    = gen_r_reg;
        poly_low_next = poly_low_reg;
        mode_next     = mode_reg;
        pad_next      = pad_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cpk_pkg::cfg_reg_t'(cfg_index))
                cpk_pkg::REG_GEN_POLY:
                begin
                    gen_r_next    = cfg_r;
                    poly_low_next = cfg_low;
                end
                cpk_pkg::REG_WORD_MODE:
                begin
                    mode_next = cfg_data[0];
                end
                cpk_pkg::REG_PAD_BITS:
                begin
                    pad_next = cfg_data[2:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_r_reg    <= R_RST;
            poly_low_reg <= LOW_RST;
            mode_reg     <= cpk_pkg::MODE_RESET;
            pad_reg      <= cpk_pkg::PAD_RESET;
        end
        else
        begin
            gen_r_reg    <= gen_r_next;
            poly_low_reg <= poly_low_next;
            mode_reg     <= mode_next;
            pad_reg      <= pad_next;
        end
    end

    // front end: accept and crc
    cpk_front #(
        .GEN_BITS (GEN_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_valid (data_valid),
        .data_stall (data_stall),
        .data_byte  (data_byte),
        .poly_low   (poly_low_reg),
        .gen_r      (gen_r_reg),
        .word_mode  (mode_reg),
        .pad_bits   (pad_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_ctl      (f_ctl),
        .q_r        (f_r),
        .q_data     (f_data),
        .rem_a      (f_rem_a),
        .rem_b      (f_rem_b)
    );

    // queue between front end and packer
    cpk_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({f_ctl, f_r, f_data, f_rem_a, f_rem_b}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_pop_data)
    );

    assign {b_ctl, b_r, b_data, b_rem_a, b_rem_b} = q_pop_data;

    // back end: bit packing and result beats
    cpk_back #(
        .GEN_BITS (GEN_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_ctl        (b_ctl),
        .q_r          (b_r),
        .q_data       (b_data),
        .rem_a        (b_rem_a),
        .rem_b        (b_rem_b),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_byte     (out_byte),
        .is_header    (is_header),
        .last_of_run  (last_of_run)
    );

endmodule

`default_nettype wire
